FILE: rtl/khs_pkg.sv
// Package for the key hash slot shard router.
// Holds the word types, opcode codes and the CRC polynomial.
// No dependencies.
`timescale 1ns / 1ps

package khs_pkg;

   // Opcode codes of a request word.
   localparam logic OP_KEY_BYTE   = 1'b0;
   localparam logic OP_RANGE_FILL = 1'b1;

   // Fixed field widths.
   localparam int SLOT_FIELD_W = 14;
   localparam int SHARD_W      = 8;
   localparam int CRC_W        = 16;

   // CRC-16 polynomial, MSB first.
   localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

   // One request word.
   typedef struct packed {
      logic                    opcode;
      logic [7:0]              key_byte;
      logic                    last_byte;
      logic [SLOT_FIELD_W-1:0] range_low;
      logic [SLOT_FIELD_W-1:0] range_high;
      logic [SHARD_W-1:0]      shard_id;
   } req_word_type;

   // One response word.
   typedef struct packed {
      logic [SLOT_FIELD_W-1:0] hash_slot;
      logic [SHARD_W-1:0]      shard_num;
   } rsp_word_type;

   // Range fill command from the front end to the fill sequencer.
   typedef struct packed {
      logic                    start;
      logic [SLOT_FIELD_W-1:0] range_low;
      logic [SLOT_FIELD_W-1:0] range_high;
      logic [SHARD_W-1:0]      shard_id;
   } fill_cmd_type;

endpackage

FILE: rtl/khs_if.sv
// Valid/ready channel interfaces for request and response words.
// Depends on khs_pkg for the word types.
`timescale 1ns / 1ps

interface khs_req_if import khs_pkg::*; ();
   logic         valid;
   logic         ready;
   req_word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface khs_rsp_if import khs_pkg::*; ();
   logic         valid;
   logic         ready;
   rsp_word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/key_hash_slot_shard_router.sv
// Key hash slot shard router: CRC-16 over key bytes, slot lookup in a map memory.
// Key bytes are taken one per cycle while no fill runs and no lookup result is held up; a last
// byte's lookup passes through the map read register, then the output register once that frees up.
// A range fill holds the request side while the sequencer writes its slots.
// After reset the map is cleared to shard 0, with no requests taken meanwhile.
// Depends on khs_pkg, khs_if, khs_crc, khs_map and khs_fill.
`timescale 1ns / 1ps

module key_hash_slot_shard_router import khs_pkg::*; #(
   parameter int SLOT_COUNT = 16384
) (
   input  logic          clock,
   input  logic          reset,
   khs_req_if.sink       req_chan,
   khs_rsp_if.source     rsp_chan
);

   localparam int ADDR_W = $clog2(SLOT_COUNT);
   localparam logic [CRC_W-1:0] SLOT_MASK = CRC_W'(SLOT_COUNT - 1);

   logic                    req_fire;
   logic                    key_fire;
   logic                    lookup_issue;
   logic                    pend_move;
   logic                    fill_busy;
   logic [CRC_W-1:0]        crc_next;
   logic [CRC_W-1:0]        slot_full;
   logic                    wr_en;
   logic [ADDR_W-1:0]       wr_addr;
   logic [SHARD_W-1:0]      wr_data;
   logic [SHARD_W-1:0]      rd_data;
   fill_cmd_type            fill_cmd;

   logic                    pend_ff,      pend_in;
   logic [SLOT_FIELD_W-1:0] pend_slot_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [SLOT_FIELD_W-1:0] rsp_slot_ff;
   logic [SHARD_W-1:0]      rsp_shard_ff;

   // A pending lookup moves to the output register when that register frees up.
   assign pend_move = !rsp_valid_ff || rsp_chan.ready;

   // Requests wait during a fill and while a lookup result cannot move on.
   assign req_chan.ready = !fill_busy && !(pend_ff && !pend_move);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign key_fire       = req_fire && (req_chan.data.opcode == OP_KEY_BYTE);
   assign lookup_issue   = key_fire && req_chan.data.last_byte;

   khs_crc u_crc (
      .clock     (clock),
      .reset     (reset),
      .fold_en   (key_fire),
      .last_byte (req_chan.data.last_byte),
      .key_byte  (req_chan.data.key_byte),
      .crc_next  (crc_next)
   );

   assign slot_full = crc_next & SLOT_MASK;

   // Range fill command.
   always_comb begin
      fill_cmd.start      = req_fire && (req_chan.data.opcode == OP_RANGE_FILL);
      fill_cmd.range_low  = req_chan.data.range_low;
      fill_cmd.range_high = req_chan.data.range_high;
      fill_cmd.shard_id   = req_chan.data.shard_id;
   end

   khs_fill #(.ADDR_W(ADDR_W)) u_fill (
      .clock   (clock),
      .reset   (reset),
      .cmd     (fill_cmd),
      .busy    (fill_busy),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   khs_map #(.ADDR_W(ADDR_W)) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (lookup_issue),
      .rd_addr (slot_full[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   // Lookup tracking and output register control.
   always_comb begin
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (pend_ff && pend_move) begin
         pend_in      = 1'b0;
         rsp_valid_in = 1'b1;
      end
      if (lookup_issue) begin
         pend_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Slot of the lookup in flight, then the response word.
   always_ff @(posedge clock) begin
      if (lookup_issue) begin
         pend_slot_ff <= slot_full[SLOT_FIELD_W-1:0];
      end
      if (pend_ff && pend_move) begin
         rsp_slot_ff  <= pend_slot_ff;
         rsp_shard_ff <= rd_data;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.data.hash_slot = rsp_slot_ff;
   assign rsp_chan.data.shard_num = rsp_shard_ff;

endmodule

FILE: rtl/khs_crc.sv
// Running CRC-16 accumulator, folding one key byte per enabled cycle.
// Depends on khs_pkg for the polynomial and widths.
`timescale 1ns / 1ps

module khs_crc import khs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             fold_en,
   input  logic             last_byte,
   input  logic [7:0]       key_byte,
   output logic [CRC_W-1:0] crc_next
);

   logic [CRC_W-1:0] crc_ff;
   logic [CRC_W-1:0] crc_in;

   // Eight shift-and-xor steps over the byte, MSB first.
   always_comb begin
      logic [CRC_W-1:0] c;
      c = crc_ff ^ {key_byte, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[CRC_W-1]) begin
            c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[CRC_W-2:0], 1'b0};
         end
      end
      crc_next = c;
   end

   // The accumulator restarts from zero after the last byte of a key.
   always_comb begin
      crc_in = crc_ff;
      if (fold_en) begin
         crc_in = last_byte ? '0 : crc_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= '0;
      end else begin
         crc_ff <= crc_in;
      end
   end

endmodule

FILE: rtl/khs_map.sv
// Slot-to-shard map memory: one write port, one registered read port.
// Depends on khs_pkg for the shard width.
`timescale 1ns / 1ps

module khs_map import khs_pkg::*; #(
   parameter int ADDR_W = 14
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [ADDR_W-1:0]  wr_addr,
   input  logic [SHARD_W-1:0] wr_data,
   input  logic               rd_en,
   input  logic [ADDR_W-1:0]  rd_addr,
   output logic [SHARD_W-1:0] rd_data
);

   logic [SHARD_W-1:0] mem [2**ADDR_W];
   logic [SHARD_W-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/khs_fill.sv
// Fill sequencer: clears the map after reset and writes slot ranges,
// one entry per cycle. Depends on khs_pkg for the command type.
`timescale 1ns / 1ps

module khs_fill import khs_pkg::*; #(
   parameter int ADDR_W = 14
) (
   input  logic               clock,
   input  logic               reset,
   input  fill_cmd_type       cmd,
   output logic               busy,
   output logic               wr_en,
   output logic [ADDR_W-1:0]  wr_addr,
   output logic [SHARD_W-1:0] wr_data
);

   localparam int CMP_W = (ADDR_W > SLOT_FIELD_W) ? ADDR_W : SLOT_FIELD_W;
   localparam logic [CMP_W-1:0] TOP_SLOT = CMP_W'(2**ADDR_W - 1);

   logic               busy_ff,  busy_in;
   logic [ADDR_W-1:0]  addr_ff,  addr_in;
   logic [ADDR_W-1:0]  end_ff,   end_in;
   logic [SHARD_W-1:0] data_ff,  data_in;
   logic [CMP_W-1:0]   lo_ext;
   logic [CMP_W-1:0]   hi_ext;
   logic [CMP_W-1:0]   hi_clip;

   // Clip the range to the map; a range starting past its end is empty.
   assign lo_ext  = CMP_W'(cmd.range_low);
   assign hi_ext  = CMP_W'(cmd.range_high);
   assign hi_clip = (hi_ext > TOP_SLOT) ? TOP_SLOT : hi_ext;

   // Walk the address from the first to the last slot of the range.
   always_comb begin
      busy_in = busy_ff;
      addr_in = addr_ff;
      end_in  = end_ff;
      data_in = data_ff;
      if (busy_ff) begin
         if (addr_ff == end_ff) begin
            busy_in = 1'b0;
         end else begin
            addr_in = addr_ff + 1'b1;
         end
      end else if (cmd.start && (lo_ext <= hi_clip)) begin
         busy_in = 1'b1;
         addr_in = lo_ext[ADDR_W-1:0];
         end_in  = hi_clip[ADDR_W-1:0];
         data_in = cmd.shard_id;
      end
   end

   // Reset starts a pass that writes zero over the whole map.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         addr_ff <= '0;
         end_ff  <= '1;
         data_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         addr_ff <= addr_in;
         end_ff  <= end_in;
         data_ff <= data_in;
      end
   end

   assign busy    = busy_ff;
   assign wr_en   = busy_ff;
   assign wr_addr = addr_ff;
   assign wr_data = data_ff;

endmodule

FILE: sim/slot_route_check.sv
// Checker for the key hash slot shard router: watches both channels, predicts routes.
// Keeps its own CRC and slot map and compares each response word with the oldest prediction.
// Depends on khs_pkg and khs_if.
`timescale 1ns / 1ps

module slot_route_check import khs_pkg::*; #(
   parameter int SLOT_COUNT = 16384
) (
   input  logic clock,
   input  logic reset,
   khs_req_if   req_mon,
   khs_rsp_if   rsp_mon,
   output int   route_errors,
   output int   routes_owed
);

   // Predicted state: running CRC and the slot-to-shard map.
   logic [CRC_W-1:0]   crc_run;
   logic [SHARD_W-1:0] shard_map [SLOT_COUNT];
   rsp_word_type       expected_routes [$];
   int                 fault_total = 0;

   // Fold one key byte into the CRC, MSB first.
   function automatic logic [CRC_W-1:0] crc16_fold(input logic [CRC_W-1:0] crc,
                                                   input logic [7:0] key_byte);
      logic [CRC_W-1:0] c;
      c = crc ^ {key_byte, 8'h00};
      for (int i = 0; i < 8; i++)
         c = c[CRC_W-1] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      return c;
   endfunction

   // Apply one accepted request word to the predicted state.
   task automatic route_request(input req_word_type w);
      logic [CRC_W-1:0] slot_bits;
      int unsigned      top_slot;
      rsp_word_type     route;
      if (w.opcode == OP_KEY_BYTE) begin
         crc_run = crc16_fold(crc_run, w.key_byte);
         if (w.last_byte) begin
            slot_bits       = crc_run & CRC_W'(SLOT_COUNT - 1);
            route.hash_slot = slot_bits[SLOT_FIELD_W-1:0];
            route.shard_num = shard_map[slot_bits];
            expected_routes.insert(expected_routes.size(), route);
            crc_run = '0;
         end
      end else begin
         // The range is clipped to the map; a reversed range writes nothing.
         top_slot = (w.range_high > SLOT_COUNT - 1) ? SLOT_COUNT - 1 : w.range_high;
         for (int unsigned j = w.range_low; j <= top_slot; j++)
            shard_map[j] = w.shard_id;
      end
   endtask

   // Count a fault; only the first few are reported.
   function automatic void note_fault(input string msg);
      fault_total++;
      if (fault_total <= 10)
         $display("%0t: route mismatch: %s", $realtime, msg);
   endfunction

   // Responses are checked before requests, since a response never belongs
   // to a request accepted at the same edge.
   always @(posedge clock) begin
      rsp_word_type want;
      rsp_word_type got;
      if (reset) begin
         crc_run = '0;
         foreach (shard_map[i]) shard_map[i] = '0;
         expected_routes.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = rsp_mon.data;
            if (expected_routes.size() == 0) begin
               note_fault($sformatf("unexpected word slot=%0d shard=%0d",
                                    got.hash_slot, got.shard_num));
            end else begin
               want = expected_routes.pop_front();
               if (got.hash_slot !== want.hash_slot)
                  note_fault($sformatf("hash_slot expected %0d got %0d",
                                       want.hash_slot, got.hash_slot));
               if (got.shard_num !== want.shard_num)
                  note_fault($sformatf("shard_num expected %0d got %0d (slot %0d)",
                                       want.shard_num, got.shard_num, want.hash_slot));
            end
         end
         if (req_mon.valid && req_mon.ready)
            route_request(req_mon.data);
      end
      route_errors <= fault_total;
      routes_owed  <= expected_routes.size();
   end

endmodule

FILE: sim/testbench.sv
// Top of the router testbench: clock, reset, request stimulus and response stalls.
// Prediction and comparison live in slot_route_check; this module gives the verdict.
// Depends on khs_pkg, khs_if, slot_route_check and the router RTL.
`timescale 1ns / 1ps

module testbench;
   import khs_pkg::*;

   localparam int SLOT_COUNT = 16384;
   localparam int LAST_SLOT  = SLOT_COUNT - 1;
   localparam int IDLE_LIMIT = 100000;
   localparam int WORD_COUNT = 1600;
   localparam int HOLD_LEN   = 300;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   route_errors;
   int   routes_owed;
   int   sender_idle_pct    = 0;
   int   receiver_stall_pct = 0;
   int   hold_requests      = 0;
   int   holds_served       = 0;
   int   hold_left          = 0;
   int   quiet_cycles       = 0;
   int   words_sent         = 0;

   khs_req_if req_if ();
   khs_rsp_if rsp_if ();

   key_hash_slot_shard_router #(.SLOT_COUNT(SLOT_COUNT)) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   slot_route_check #(.SLOT_COUNT(SLOT_COUNT)) u_check (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_if),
      .rsp_mon      (rsp_if),
      .route_errors (route_errors),
      .routes_owed  (routes_owed)
   );

   always #10 clock = ~clock;

   // Receiver: random stalls, plus a long hold-off whenever one is asked for.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left    <= hold_left - 1;
         rsp_if.ready <= 1'b0;
      end else if (holds_served != hold_requests) begin
         holds_served <= holds_served + 1;
         hold_left    <= HOLD_LEN - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // Watchdog on cycles in which neither channel moves a word.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Key byte word; the range fields are ignored by the block and left random.
   function automatic req_word_type key_word(input logic [7:0] key_byte, input logic last);
      req_word_type w;
      w.opcode     = OP_KEY_BYTE;
      w.key_byte   = key_byte;
      w.last_byte  = last;
      w.range_low  = SLOT_FIELD_W'($urandom_range(LAST_SLOT));
      w.range_high = SLOT_FIELD_W'($urandom_range(LAST_SLOT));
      w.shard_id   = SHARD_W'($urandom_range(255));
      return w;
   endfunction

   // Range fill word; the key fields are ignored by the block and left random.
   function automatic req_word_type fill_word(input int lo, input int hi, input int shard);
      req_word_type w;
      w.opcode     = OP_RANGE_FILL;
      w.key_byte   = 8'($urandom_range(255));
      w.last_byte  = 1'($urandom_range(1));
      w.range_low  = SLOT_FIELD_W'(lo);
      w.range_high = SLOT_FIELD_W'(hi);
      w.shard_id   = SHARD_W'(shard);
      return w;
   endfunction

   // Offer one word after a random gap and return at the edge that accepts it.
   task automatic send_word(input req_word_type w);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data  <= w;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      words_sent++;
   endtask

   // Stop offering and wait until every predicted route has come back.
   task automatic drain_routes();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (routes_owed != 0) @(posedge clock);
   endtask

   // Fill of random span: mostly short, sometimes up to the whole map.
   task automatic random_fill();
      int kind;
      int span;
      int lo;
      kind = $urandom_range(99);
      if (kind < 70)
         span = $urandom_range(31);
      else if (kind < 95)
         span = $urandom_range(1023, 32);
      else
         span = $urandom_range(LAST_SLOT, 1024);
      lo = $urandom_range(LAST_SLOT - span);
      send_word(fill_word(lo, lo + span, $urandom_range(255)));
   endtask

   // One random sequence: mostly whole keys, some fills, a few reversed ranges.
   task automatic random_sequence();
      int pick;
      int len;
      int split;
      int lo;
      pick = $urandom_range(99);
      if (pick < 88) begin
         len   = ($urandom_range(3) == 0) ? $urandom_range(16, 5) : $urandom_range(4, 1);
         // Now and then a fill lands inside a key and must leave its CRC alone.
         split = (len > 1 && $urandom_range(9) == 0) ? $urandom_range(len - 1, 1) : 0;
         for (int i = 0; i < len; i++) begin
            if (split != 0 && i == split)
               random_fill();
            send_word(key_word(8'($urandom_range(255)), i == len - 1));
         end
      end else if (pick < 96) begin
         random_fill();
      end else begin
         lo = $urandom_range(LAST_SLOT, 1);
         send_word(fill_word(lo, $urandom_range(lo - 1), $urandom_range(255)));
      end
   endtask

   initial begin
      int idle_by_phase [4];
      int stall_by_phase [4];
      idle_by_phase  = '{0, 52, 0, 35};
      stall_by_phase = '{0, 0, 52, 35};
      req_if.valid = 1'b0;
      req_if.data  = '0;
      rsp_if.ready = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed words: byte extremes, whole-map and edge fills, a reversed
      // range, a fill inside a key, and the standard check string.
      send_word(key_word(8'h00, 1'b1));
      send_word(key_word(8'hFF, 1'b1));
      send_word(fill_word(0, LAST_SLOT, 8'hA5));
      send_word(key_word(8'h00, 1'b1));
      send_word(fill_word(LAST_SLOT, LAST_SLOT, 8'hFF));
      send_word(fill_word(0, 0, 8'h00));
      send_word(fill_word(LAST_SLOT, 0, 8'h5A));
      send_word(key_word(8'h00, 1'b1));
      send_word(key_word(8'hFF, 1'b1));
      send_word(key_word(8'h61, 1'b0));
      send_word(fill_word(0, LAST_SLOT / 2, 8'h3C));
      send_word(key_word(8'h62, 1'b1));
      for (int i = 1; i <= 9; i++)
         send_word(key_word(8'h30 + 8'(i), i == 9));
      drain_routes();

      // Long response hold-off while the sender keeps offering key bytes.
      hold_requests++;
      for (int i = 0; i < 60; i++)
         send_word(key_word(8'($urandom_range(255)), $urandom_range(2) == 0));
      send_word(key_word(8'($urandom_range(255)), 1'b1));
      drain_routes();

      // Random words in phases of sender gaps and receiver stalls.
      for (int phase = 0; phase < 4; phase++) begin
         sender_idle_pct    = idle_by_phase[phase];
         receiver_stall_pct = stall_by_phase[phase];
         while (words_sent < (phase + 1) * WORD_COUNT / 4)
            random_sequence();
         drain_routes();
      end

      repeat (20) @(posedge clock);
      if (route_errors == 0 && routes_owed == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
